FILE: rtl/ukq_pkg.sv
// Shared constants, command and status codes for the unique-key first-fit queue.
package ukq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned SIZE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned ENTRY_W  = KEY_W + SIZE_W;

  localparam int unsigned IN_DATA_W  = KEY_W + SIZE_W + SIZE_W;
  localparam int unsigned OUT_DATA_W = 80;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_REMOVED   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NONE_FITS = 3'd4;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [KEY_W-1:0]  key;
  } entry_t;

endpackage

FILE: rtl/unique_key_queue_first_fit_removal_core.sv
// Top level: command sequencer, slot scan, gap-closing shift and result register.
//
//  Channel  Direction  Handshake              Contents
//  s_axis   in         tvalid/tready          tuser: cmd; tdata: key, size, limit
//  m_axis   out        tvalid/tready          tuser: status; tdata: key, size, occupancy
//
// A command is taken only while the sequencer is idle and the result register is empty.
// One slot is read per cycle, with the compare made in the cycle after its read. An insert
// first scans every held entry for a duplicate key; a removal scans up to the first entry
// that fits and then shifts each later entry down one slot to close the gap. Reset empties
// the queue at once; slot contents are not cleared. A stalled result only holds off the
// next command.
module unique_key_queue_first_fit_removal_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: entry_key[63:0], entry_size[71:64], size_limit[79:72]
  input  logic [ukq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: cmd[0]
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: removed_key[63:0], removed_size[71:64], occupancy[76:72], zeros[79:77]
  output logic [ukq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: status[2:0]
  output logic [ukq_pkg::STATUS_W-1:0]   m_axis_tuser
);
  import ukq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] chk_idx_q, chk_idx_d;
  logic             chk_valid_q, chk_valid_d;

  logic              cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W-1:0] limit_q;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [KEY_W-1:0]    out_key_q, out_key_d;
  logic [SIZE_W-1:0]   out_size_q, out_size_d;
  logic [OCC_W-1:0]    out_occ_q, out_occ_d;

  logic             accept;
  logic             issue;
  logic             hit;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;

  assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign issue         = (idx_q < count_q);

  ukq_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ukq_match u_match (
    .cmd_i       (cmd_q),
    .entry_i     (mem_rdata),
    .probe_key_i (key_q),
    .limit_i     (limit_q),
    .hit_o       (hit)
  );

  // The same index register walks the scan and, from the slot past the hit, the shift.
  assign mem_raddr = idx_q[IDX_W-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_q[IDX_W-1:0];
    mem_wdata = '{size: size_q, key: key_q};
    if (state_q == S_SHIFT && chk_valid_q) begin
      mem_we    = 1'b1;
      mem_waddr = IDX_W'(chk_idx_q - CNT_W'(1));
      mem_wdata = mem_rdata;
    end else if (state_q == S_WRITE) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    chk_idx_d    = chk_idx_q;
    chk_valid_d  = 1'b0;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_key_d    = out_key_q;
    out_size_d   = out_size_q;
    out_occ_d    = out_occ_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
          idx_d   = '0;
        end
      end
      S_SCAN: begin
        if (chk_valid_q && hit) begin
          if (cmd_q == CMD_INSERT) begin
            out_valid_d  = 1'b1;
            out_status_d = STAT_DUPLICATE;
            out_key_d    = '0;
            out_size_d   = '0;
            out_occ_d    = OCC_W'(count_q);
            state_d      = S_IDLE;
          end else begin
            out_key_d  = mem_rdata.key;
            out_size_d = mem_rdata.size;
            idx_d      = chk_idx_q + CNT_W'(1);
            state_d    = S_SHIFT;
          end
        end else if (issue) begin
          chk_valid_d = 1'b1;
          chk_idx_d   = idx_q;
          idx_d       = idx_q + CNT_W'(1);
        end else if (!chk_valid_q) begin
          // Every held entry has been checked without a hit.
          if (cmd_q == CMD_REMOVE) begin
            out_valid_d  = 1'b1;
            out_status_d = STAT_NONE_FITS;
            out_key_d    = '0;
            out_size_d   = '0;
            out_occ_d    = OCC_W'(count_q);
            state_d      = S_IDLE;
          end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
            out_valid_d  = 1'b1;
            out_status_d = STAT_FULL;
            out_key_d    = '0;
            out_size_d   = '0;
            out_occ_d    = OCC_W'(count_q);
            state_d      = S_IDLE;
          end else begin
            state_d = S_WRITE;
          end
        end
      end
      S_SHIFT: begin
        if (issue) begin
          chk_valid_d = 1'b1;
          chk_idx_d   = idx_q;
          idx_d       = idx_q + CNT_W'(1);
        end else if (!chk_valid_q) begin
          count_d      = count_q - CNT_W'(1);
          out_valid_d  = 1'b1;
          out_status_d = STAT_REMOVED;
          out_occ_d    = OCC_W'(count_q - CNT_W'(1));
          state_d      = S_IDLE;
        end
      end
      S_WRITE: begin
        count_d      = count_q + CNT_W'(1);
        out_valid_d  = 1'b1;
        out_status_d = STAT_INSERTED;
        out_key_d    = '0;
        out_size_d   = '0;
        out_occ_d    = OCC_W'(count_q + CNT_W'(1));
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      chk_idx_q   <= '0;
      chk_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      chk_idx_q   <= chk_idx_d;
      chk_valid_q <= chk_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= s_axis_tuser;
      key_q   <= s_axis_tdata[KEY_W-1:0];
      size_q  <= s_axis_tdata[KEY_W +: SIZE_W];
      limit_q <= s_axis_tdata[KEY_W+SIZE_W +: SIZE_W];
    end
    out_status_q <= out_status_d;
    out_key_q    <= out_key_d;
    out_size_q   <= out_size_d;
    out_occ_q    <= out_occ_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {(OUT_DATA_W - KEY_W - SIZE_W - OCC_W)'(0),
                          out_occ_q, out_size_q, out_key_q};

endmodule

FILE: rtl/ukq_store.sv
// Slot memory: one write port and one read port with registered read data.
module ukq_store (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ukq_pkg::IDX_W-1:0] waddr_i,
  input  ukq_pkg::entry_t       wdata_i,
  input  logic [ukq_pkg::IDX_W-1:0] raddr_i,
  output ukq_pkg::entry_t       rdata_o
);
  import ukq_pkg::*;

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ukq_match.sv
// Shared compare unit: key equality for inserts, size-within-limit for removals.
module ukq_match (
  input  logic                        cmd_i,
  input  ukq_pkg::entry_t             entry_i,
  input  logic [ukq_pkg::KEY_W-1:0]   probe_key_i,
  input  logic [ukq_pkg::SIZE_W-1:0]  limit_i,
  output logic                        hit_o
);
  import ukq_pkg::*;

  always_comb begin
    if (cmd_i == CMD_INSERT) begin
      hit_o = (entry_i.key == probe_key_i);
    end else begin
      hit_o = (entry_i.size <= limit_i);
    end
  end

endmodule
